>>> hw/rtl/cnlc_pkg.sv
// Shared types, constants and microcode table for the card number checker.
`default_nettype none

package cnlc_pkg;

	localparam int IN_W           = 54;
	localparam int IN_BYTES_W     = 56;
	localparam int OUT_BYTES_W    = 8;
	localparam int MAX_DIGITS_DEF = 16;

	localparam int DABBLE_STEPS   = 8;
	localparam int DABBLE_PASSES  = 7;
	localparam int BIN_W          = DABBLE_STEPS * DABBLE_PASSES;
	localparam int BCD_DIGITS     = 17;
	localparam int BCD_W          = BCD_DIGITS * 4;
	localparam int PASS_W         = $clog2(DABBLE_PASSES + 1);
	localparam int PTR_W          = $clog2(BCD_DIGITS + 1);

	localparam logic [1:0] CLASS_INVALID = 2'd0;
	localparam logic [1:0] CLASS_34_37   = 2'd1;
	localparam logic [1:0] CLASS_51_55   = 2'd2;
	localparam logic [1:0] CLASS_4       = 2'd3;

	localparam int PC_W = 2;

	localparam logic [PC_W-1:0] STEP_LOAD   = 2'd0;
	localparam logic [PC_W-1:0] STEP_DABBLE = 2'd1;
	localparam logic [PC_W-1:0] STEP_LUHN   = 2'd2;
	localparam logic [PC_W-1:0] STEP_EMIT   = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_DABBLE,
		OP_LUHN,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_NO_INPUT,
		COND_PASS_LEFT,
		COND_DIGIT_LEFT,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] jmp;
		logic [PC_W-1:0] nxt;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			STEP_LOAD:   w = '{OP_LOAD,   COND_NO_INPUT,   STEP_LOAD,   STEP_DABBLE};
			STEP_DABBLE: w = '{OP_DABBLE, COND_PASS_LEFT,  STEP_DABBLE, STEP_LUHN};
			STEP_LUHN:   w = '{OP_LUHN,   COND_DIGIT_LEFT, STEP_LUHN,   STEP_EMIT};
			STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_BUSY,   STEP_EMIT,   STEP_LOAD};
			default:     w = '{OP_LOAD,   COND_NO_INPUT,   STEP_LOAD,   STEP_DABBLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/card_number_luhn_classifier_unit.sv
// Top level: microcoded Luhn mod-10 checker and issuer classifier for card numbers.
// Each accepted word runs 7 double-dabble passes, then 17 Luhn digit steps, then an
// emit step; a new word is accepted only in the load step that follows the emit.
// A pending result waits in the output register while the next word is accepted.
// Reset: arst_n asynchronous, active low; clears the step counter and output valid.
`default_nettype none

module card_number_luhn_classifier_unit #(
	parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [cnlc_pkg::IN_BYTES_W-1:0] s_tdata,  // [53:0] card_number
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [cnlc_pkg::OUT_BYTES_W-1:0]     m_tdata   // [0] checksum_ok, [2:1] card_class
);

	logic [cnlc_pkg::PC_W-1:0]   pc_q;
	cnlc_pkg::ucode_t            uw;
	logic                        take;
	logic [cnlc_pkg::BIN_W-1:0]  bin_q;
	logic [cnlc_pkg::BCD_W-1:0]  bcd_q;
	logic [cnlc_pkg::BIN_W-1:0]  bin_c;
	logic [cnlc_pkg::BCD_W-1:0]  bcd_c;
	logic [cnlc_pkg::PASS_W-1:0] pass_q;
	logic [cnlc_pkg::PTR_W-1:0]  ptr_q;
	logic [3:0]                  sum_q;
	logic [3:0]                  sum_n;
	logic [3:0]                  dig;
	logic [4:0]                  dbl;
	logic [4:0]                  wgt;
	logic [4:0]                  acc;
	logic                        out_busy;
	logic                        too_long;
	logic [1:0]                  cls_c;
	logic                        ok_c;
	logic                        m_tvalid_q;
	logic                        ok_q;
	logic [1:0]                  class_q;

	assign uw       = cnlc_pkg::ucode_rom(pc_q);
	assign out_busy = m_tvalid_q && !m_tready;
	assign s_tready = (uw.op == cnlc_pkg::OP_LOAD);

	always_comb begin
		unique case (uw.cond)
			cnlc_pkg::COND_NO_INPUT:   take = !s_tvalid;
			cnlc_pkg::COND_PASS_LEFT:
				take = pass_q != cnlc_pkg::PASS_W'(cnlc_pkg::DABBLE_PASSES - 1);
			cnlc_pkg::COND_DIGIT_LEFT:
				take = ptr_q != cnlc_pkg::PTR_W'(cnlc_pkg::BCD_DIGITS - 1);
			cnlc_pkg::COND_OUT_BUSY:   take = out_busy;
			default:                   take = 1'b0;
		endcase
	end

	always_comb begin
		bcd_c = bcd_q;
		bin_c = bin_q;
		for (int s = 0; s < cnlc_pkg::DABBLE_STEPS; s++) begin
			for (int i = 0; i < cnlc_pkg::BCD_DIGITS; i++) begin
				if (bcd_c[i*4 +: 4] >= 4'd5) begin
					bcd_c[i*4 +: 4] = bcd_c[i*4 +: 4] + 4'd3;
				end
			end
			bcd_c = {bcd_c[cnlc_pkg::BCD_W-2:0], bin_c[cnlc_pkg::BIN_W-1]};
			bin_c = {bin_c[cnlc_pkg::BIN_W-2:0], 1'b0};
		end
	end

	always_comb begin
		dig = bcd_q[ptr_q*4 +: 4];
		dbl = {dig, 1'b0};
		if (ptr_q[0]) begin
			wgt = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
		end else begin
			wgt = {1'b0, dig};
		end
		acc   = {1'b0, sum_q} + wgt;
		sum_n = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
	end

	always_comb begin
		logic [3:0] d16, d15, d14, d13, d12;
		d16      = bcd_q[16*4 +: 4];
		d15      = bcd_q[15*4 +: 4];
		d14      = bcd_q[14*4 +: 4];
		d13      = bcd_q[13*4 +: 4];
		d12      = bcd_q[12*4 +: 4];
		too_long = 1'b0;
		for (int i = 0; i < cnlc_pkg::BCD_DIGITS; i++) begin
			if (i >= MAX_DIGITS && bcd_q[i*4 +: 4] != 4'd0) begin
				too_long = 1'b1;
			end
		end
		if (d16 == 4'd0 && d15 == 4'd0 && d14 == 4'd3 && (d13 == 4'd4 || d13 == 4'd7)) begin
			cls_c = cnlc_pkg::CLASS_34_37;
		end else if (d16 == 4'd0 && d15 == 4'd5 && d14 >= 4'd1 && d14 <= 4'd5) begin
			cls_c = cnlc_pkg::CLASS_51_55;
		end else if ((d16 == 4'd0 && d15 == 4'd4) ||
			(d16 == 4'd0 && d15 == 4'd0 && d14 == 4'd0 && d13 == 4'd0 && d12 == 4'd4)) begin
			cls_c = cnlc_pkg::CLASS_4;
		end else begin
			cls_c = cnlc_pkg::CLASS_INVALID;
		end
		ok_c = !too_long && (sum_q == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= cnlc_pkg::STEP_LOAD;
			m_tvalid_q <= 1'b0;
			pass_q     <= '0;
			ptr_q      <= '0;
		end else begin
			pc_q <= take ? uw.jmp : uw.nxt;
			if (uw.op == cnlc_pkg::OP_EMIT && !out_busy) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (uw.op)
				cnlc_pkg::OP_LOAD: begin
					pass_q <= '0;
					ptr_q  <= '0;
				end
				cnlc_pkg::OP_DABBLE: pass_q <= pass_q + cnlc_pkg::PASS_W'(1);
				cnlc_pkg::OP_LUHN:   ptr_q  <= ptr_q + cnlc_pkg::PTR_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			cnlc_pkg::OP_LOAD: begin
				bin_q <= cnlc_pkg::BIN_W'(s_tdata[cnlc_pkg::IN_W-1:0]);
				bcd_q <= '0;
				sum_q <= 4'd0;
			end
			cnlc_pkg::OP_DABBLE: begin
				bin_q <= bin_c;
				bcd_q <= bcd_c;
			end
			cnlc_pkg::OP_LUHN: sum_q <= sum_n;
			cnlc_pkg::OP_EMIT: begin
				if (!out_busy) begin
					ok_q    <= ok_c;
					class_q <= ok_c ? cls_c : cnlc_pkg::CLASS_INVALID;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, class_q, ok_q};

endmodule

`default_nettype wire

>>> hw/rtl/cnlc_checker.sv
// Port-level checker for the card number checker, bound to the top level.
`default_nettype none

module cnlc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [cnlc_pkg::IN_BYTES_W-1:0] s_tdata,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [cnlc_pkg::OUT_BYTES_W-1:0] m_tdata
);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready && (s_tdata == s_tdata);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_class_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:1] != cnlc_pkg::CLASS_INVALID |-> m_tdata[0])
		else $error("class reported with failed checksum");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("input accepted while word in progress");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && !m_tvalid |=> !m_tvalid)
		else $error("result word appeared right after accept");

endmodule

bind card_number_luhn_classifier_unit cnlc_checker u_cnlc_checker (.*);

`default_nettype wire
